FILE: design/mpog_pkg.sv
// shared types, constants and microcode program for the merkle proof offset generator
// no dependencies; imported by merkle_proof_offset_generator_unit
`timescale 1ns / 1ps

package mpog_pkg;

  localparam int BLOCK_BYTES     = 1024;
  localparam int MAX_BLOCKS_LOG2 = 20;
  localparam int HASH_BYTES      = 32;

  localparam int BLOCK_SHIFT = $clog2(BLOCK_BYTES);
  localparam int HASH_SHIFT  = $clog2(HASH_BYTES);
  localparam int STACK_DEPTH = MAX_BLOCKS_LOG2 + 1;
  localparam int MAX_HASHES  = 2 * MAX_BLOCKS_LOG2;

  // field widths
  localparam int LEN_W  = 30;
  localparam int OFF_W  = 26;
  localparam int SIZE_W = 10;
  localparam int BLK_W  = 21;
  localparam int CNT_W  = 6;
  localparam int PAY_W  = 12;

  localparam int IDX_W = BLK_W + 1;
  localparam int SP_W  = $clog2(STACK_DEPTH + 1);
  localparam int PTR_W = $clog2(STACK_DEPTH);

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [BLK_W-1:0] from;
    logic [BLK_W-1:0] to;
  } node_t;

  // micro-program counter, one-hot
  typedef enum logic [8:0] {
    S_WAIT  = 9'b000000001,
    S_CHECK = 9'b000000010,
    S_VISIT = 9'b000000100,
    S_DESC  = 9'b000001000,
    S_EMCHK = 9'b000010000,
    S_EMIT  = 9'b000100000,
    S_POP   = 9'b001000000,
    S_SUM   = 9'b010000000,
    S_ERR   = 9'b100000000
  } step_t;

  typedef enum logic [2:0] {
    C_NONE,
    C_BAD,
    C_OUTSIDE,
    C_FULL,
    C_INNER,
    C_EMPTY
  } cond_t;

  typedef enum logic [2:0] {
    A_NONE,
    A_LOAD,
    A_SETUP,
    A_SPLIT,
    A_COUNT,
    A_POP
  } act_t;

  typedef enum logic [1:0] {
    O_NONE,
    O_HASH,
    O_SUM,
    O_ERR
  } osel_t;

  typedef struct packed {
    logic  wait_in;
    logic  wait_out;
    osel_t osel;
    cond_t cond;
    act_t  act;
    step_t jump_to;
    step_t next_to;
  } ucode_t;

  // control store: action runs only on the fall-through path
  function automatic ucode_t ucode_rom(step_t s);
    ucode_t w;
    begin
      case (s)
        S_WAIT:  w = '{1'b1, 1'b0, O_NONE, C_NONE,    A_LOAD,  S_WAIT,  S_CHECK};
        S_CHECK: w = '{1'b0, 1'b0, O_NONE, C_BAD,     A_SETUP, S_ERR,   S_VISIT};
        S_VISIT: w = '{1'b0, 1'b0, O_NONE, C_OUTSIDE, A_NONE,  S_EMCHK, S_DESC};
        S_DESC:  w = '{1'b0, 1'b0, O_NONE, C_INNER,   A_SPLIT, S_POP,   S_VISIT};
        S_EMCHK: w = '{1'b0, 1'b0, O_NONE, C_FULL,    A_NONE,  S_POP,   S_EMIT};
        S_EMIT:  w = '{1'b0, 1'b1, O_HASH, C_NONE,    A_COUNT, S_POP,   S_POP};
        S_POP:   w = '{1'b0, 1'b0, O_NONE, C_EMPTY,   A_POP,   S_SUM,   S_VISIT};
        S_SUM:   w = '{1'b0, 1'b1, O_SUM,  C_NONE,    A_NONE,  S_WAIT,  S_WAIT};
        S_ERR:   w = '{1'b0, 1'b1, O_ERR,  C_NONE,    A_NONE,  S_WAIT,  S_WAIT};
        default: w = '{1'b0, 1'b0, O_NONE, C_NONE,    A_NONE,  S_WAIT,  S_WAIT};
      endcase
      return w;
    end
  endfunction

  // largest power of two strictly below n, for n >= 2: top bit of n - 1
  function automatic logic [BLK_W-1:0] split_size(logic [BLK_W-1:0] n);
    logic [BLK_W-1:0] m;
    begin
      m = n - BLK_W'(1);
      m = m | (m >> 1);
      m = m | (m >> 2);
      m = m | (m >> 4);
      m = m | (m >> 8);
      m = m | (m >> 16);
      return m ^ (m >> 1);
    end
  endfunction

endpackage

FILE: design/merkle_proof_offset_generator_unit.sv
// merkle proof offset generator: microcoded tree walk with node stack
// depends on mpog_pkg (types, constants, control store)
`timescale 1ns / 1ps

// Usage:
// A request transaction (total_length, region_start, region_end) is taken on
// in_valid/in_ready. in_ready is high only while the sequencer waits at its
// first step, so one request is in work at a time.
// For a good request the block sends one transaction per needed hash (kind 0,
// digest_offset) in left-to-right order, then one summary transaction (kind 1,
// last 1). A bad request gives only the summary with status 1.
// The micro-program runs one step per cycle unless stalled: it takes the
// request, checks it, then for each tree node visited splits the node,
// passes over it when it is wholly inside the region, or sends its hash;
// the summary comes last. The walk pauses while out_ready is held low.
// A stalled receiver freezes the sequencer on the step that shows the result;
// the result fields stay put until the transaction completes.
// The next request can be taken in the cycle after the summary is taken.
// Reset returns the sequencer to its waiting step and clears the stack
// pointer and hash count; stack contents are written before they are read.
module merkle_proof_offset_generator_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [mpog_pkg::LEN_W-1:0]  total_length,
  input  logic [mpog_pkg::LEN_W-1:0]  region_start,
  input  logic [mpog_pkg::LEN_W-1:0]  region_end,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        kind,
  output logic [mpog_pkg::OFF_W-1:0]  digest_offset,
  output logic [mpog_pkg::LEN_W-1:0]  head_start,
  output logic [mpog_pkg::SIZE_W-1:0] lead_bytes,
  output logic [mpog_pkg::SIZE_W-1:0] trail_bytes,
  output logic [mpog_pkg::BLK_W-1:0]  total_blocks,
  output logic [mpog_pkg::BLK_W-1:0]  region_blocks,
  output logic [mpog_pkg::CNT_W-1:0]  hash_total,
  output logic [mpog_pkg::PAY_W-1:0]  payload_bytes,
  output logic                        status,
  output logic                        last
);
  import mpog_pkg::*;

  step_t  step;
  step_t  step_next;
  ucode_t uw;

  logic [LEN_W-1:0]  len_r;
  logic [LEN_W-1:0]  start_r;
  logic [LEN_W-1:0]  end_r;
  logic [BLK_W-1:0]  nb;
  logic [BLK_W-1:0]  bf;
  logic [BLK_W-1:0]  bt;
  logic [SIZE_W-1:0] tail;
  logic [SP_W-1:0]   sp;
  logic [CNT_W-1:0]  cnt;
  node_t             cur;
  node_t             node_stack [STACK_DEPTH];

  logic              stall;
  logic              cond_hit;
  logic              advance;
  logic              do_act;
  logic              bad;
  logic [BLK_W-1:0]  nb_calc;
  logic [BLK_W-1:0]  bt_calc;
  logic [SIZE_W-1:0] tail_up;
  logic [LEN_W:0]    block_end;
  logic [SIZE_W-1:0] tail_calc;
  logic [BLK_W-1:0]  node_size;
  logic [BLK_W-1:0]  half;
  logic [IDX_W-1:0]  hidx;
  node_t             right;
  logic [PTR_W-1:0]  top;

  assign uw = ucode_rom(step);

  // request decode
  assign bad = (start_r == '0) || (start_r >= end_r) || (end_r > len_r);

  assign nb_calc   = BLK_W'(len_r >> BLOCK_SHIFT) + BLK_W'(|len_r[BLOCK_SHIFT-1:0]);
  assign bt_calc   = BLK_W'(end_r >> BLOCK_SHIFT) + BLK_W'(|end_r[BLOCK_SHIFT-1:0]);
  // bytes up to the next block boundary
  assign tail_up   = SIZE_W'(-end_r[BLOCK_SHIFT-1:0]);
  assign block_end = (LEN_W+1)'(end_r) + (LEN_W+1)'(tail_up);
  assign tail_calc = (block_end > (LEN_W+1)'(len_r)) ? SIZE_W'(len_r - end_r) : tail_up;

  // tree walk datapath
  assign node_size = cur.to - cur.from;
  assign half      = split_size(node_size);
  assign hidx      = cur.idx + IDX_W'({node_size, 1'b0}) - IDX_W'(2);
  assign right.idx  = cur.idx + IDX_W'({half, 1'b0}) - IDX_W'(1);
  assign right.from = cur.from + half;
  assign right.to   = cur.to;
  assign top        = PTR_W'(sp - SP_W'(1));

  always_comb begin
    case (uw.cond)
      C_NONE:    cond_hit = 1'b0;
      C_BAD:     cond_hit = bad;
      C_OUTSIDE: cond_hit = (cur.to <= bf) || (cur.from >= bt);
      C_FULL:    cond_hit = cnt >= CNT_W'(MAX_HASHES);
      C_INNER:   cond_hit = ((cur.from >= bf) && (cur.to <= bt)) || (node_size < BLK_W'(2));
      C_EMPTY:   cond_hit = sp == '0;
      default:   cond_hit = 1'b0;
    endcase
  end

  assign stall     = (uw.wait_in && !in_valid) || (uw.wait_out && !out_ready);
  assign advance   = !stall;
  assign do_act    = advance && !cond_hit;
  assign step_next = !advance ? step : (cond_hit ? uw.jump_to : uw.next_to);

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= S_WAIT;
    end else begin
      step <= step_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sp  <= '0;
      cnt <= '0;
    end else if (do_act) begin
      case (uw.act)
        A_SETUP: begin
          sp  <= '0;
          cnt <= '0;
        end
        A_SPLIT: begin
          if (sp < SP_W'(STACK_DEPTH)) begin
            sp <= sp + SP_W'(1);
          end
        end
        A_COUNT: cnt <= cnt + CNT_W'(1);
        A_POP:   sp  <= sp - SP_W'(1);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_act) begin
      case (uw.act)
        A_LOAD: begin
          len_r   <= total_length;
          start_r <= region_start;
          end_r   <= region_end;
        end
        A_SETUP: begin
          nb       <= nb_calc;
          bf       <= BLK_W'(start_r >> BLOCK_SHIFT);
          bt       <= bt_calc;
          tail     <= tail_calc;
          cur.idx  <= '0;
          cur.from <= '0;
          cur.to   <= nb_calc;
        end
        A_SPLIT: begin
          if (sp < SP_W'(STACK_DEPTH)) begin
            node_stack[PTR_W'(sp)] <= right;
          end
          cur.to <= cur.from + half;
        end
        A_POP:   cur <= node_stack[top];
        default: ;
      endcase
    end
  end

  // result fields
  always_comb begin
    in_ready      = uw.wait_in;
    out_valid     = uw.osel != O_NONE;
    kind          = 1'b0;
    digest_offset = '0;
    head_start    = '0;
    lead_bytes    = '0;
    trail_bytes   = '0;
    total_blocks  = '0;
    region_blocks = '0;
    hash_total    = '0;
    payload_bytes = '0;
    status        = 1'b0;
    last          = 1'b0;
    case (uw.osel)
      O_HASH: begin
        digest_offset = OFF_W'(hidx) << HASH_SHIFT;
      end
      O_SUM: begin
        kind          = 1'b1;
        head_start    = LEN_W'(bf) << BLOCK_SHIFT;
        lead_bytes    = start_r[SIZE_W-1:0];
        trail_bytes   = tail;
        total_blocks  = nb;
        region_blocks = bt - bf;
        hash_total    = cnt;
        payload_bytes = PAY_W'(start_r[SIZE_W-1:0]) + PAY_W'(tail)
                        + (PAY_W'(cnt) << HASH_SHIFT);
        last          = 1'b1;
      end
      O_ERR: begin
        kind   = 1'b1;
        status = 1'b1;
        last   = 1'b1;
      end
      default: ;
    endcase
  end

endmodule
